// ----- hw/rtl/aspcm_pkg.sv -----
// ----------------------------------------------------------------------------
// aspcm_pkg: shared types and constants for the sample-to-PCM16 converter
// Payload structs of the request and response channels, register indexes
// and the numeric constants of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package aspcm_pkg;

   typedef struct packed {
      logic [63:0] sample_bytes;
      logic        last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               last_out;
   } rsp_payload_type;

   // Configuration register indexes.
   localparam logic CSR_SAMPLE_FORMAT = 1'b0;
   localparam logic CSR_SAMPLE_BITS   = 1'b1;

   // Sample format codes.
   localparam logic FMT_PCM   = 1'b0;
   localparam logic FMT_FLOAT = 1'b1;

   // Sample widths.
   localparam logic [6:0] BITS_8  = 7'd8;
   localparam logic [6:0] BITS_16 = 7'd16;
   localparam logic [6:0] BITS_24 = 7'd24;
   localparam logic [6:0] BITS_32 = 7'd32;

   // Double-precision exponent bookkeeping.
   localparam logic [10:0] EXP_MAX       = 11'h7FF;
   localparam logic [10:0] F32_TO_F64    = 11'd896;
   localparam logic [11:0] EXP_SAT_MIN   = 12'd1038;
   localparam logic [11:0] EXP_ZERO_MAX  = 12'd1019;
   localparam logic [11:0] EXP_SHIFT_REF = 12'd1074;
   // Scaled magnitudes in [0.25, 0.5) carry this exponent sum.
   localparam logic [11:0] EXP_QUARTER   = 12'd1021;

   localparam logic [15:0] PCM_POS_MAX = 16'h7FFF;
   localparam logic [15:0] PCM_NEG_MAX = 16'h8000;

endpackage

`default_nettype wire

// ----- hw/rtl/audio_sample_to_pcm16_unit.sv -----
// ----------------------------------------------------------------------------
// audio_sample_to_pcm16_unit: audio sample to signed 16-bit PCM converter
// Converts one little-endian PCM or IEEE float sample per clock into a
// signed 16-bit sample through a four-stage pipeline.
// ----------------------------------------------------------------------------
// The unit takes one sample transaction in every clock cycle and returns
// exactly one result transaction for each, in order, from the stage four
// register. busy never rises, so start may be held high continuously. The
// result is on rsp_payload for one cycle while rsp_valid is high; the
// receiver cannot stall it and must take it in that cycle. The stages follow
// the float path: stage one decodes the sample, stage two forms the
// exact product with 32767, stage three rounds it to double precision and
// stage four rounds to an integer and saturates. Integer PCM samples ride
// the same pipeline. Configuration is written through csr_*, which is always
// ready, and must only change while no sample is in flight.
`default_nettype none

module audio_sample_to_pcm16_unit
   import aspcm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output      logic            busy,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_valid,
   output      logic            csr_ready,
   input  wire logic            csr_index,
   input  wire logic [6:0]      csr_data
);

   // Configuration registers.
   logic       format_ff, format_in;
   logic [6:0] bits_ff, bits_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      format_in = format_ff;
      bits_in   = bits_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_FORMAT: format_in = csr_data[0];
            CSR_SAMPLE_BITS:   bits_in   = csr_data;
            default:           format_in = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_PCM;
         bits_ff   <= BITS_16;
      end else begin
         format_ff <= format_in;
         bits_ff   <= bits_in;
      end
   end

   // Stage 1: decode. Float32 is widened to double fields. Special values
   // (NaN, zero and subnormals, which round to zero, and infinity, which
   // saturates) are flagged here and bypass the arithmetic.
   logic        s1_valid_ff;
   logic        s1_last_ff, s1_float_ff, s1_sign_ff, s1_zero_ff, s1_sat_ff;
   logic [10:0] s1_exp_ff;
   logic [52:0] s1_mant_ff;
   logic [15:0] s1_int_ff;

   logic [63:0] raw;
   logic        s1_sign_in, s1_zero_in, s1_sat_in;
   logic [10:0] s1_exp_in;
   logic [52:0] s1_mant_in;
   logic [15:0] s1_int_in;
   logic        accept;

   assign raw    = req_payload.sample_bytes;
   assign accept = start && !busy;

   always_comb begin
      s1_sign_in = 1'b0;
      s1_zero_in = 1'b0;
      s1_sat_in  = 1'b0;
      s1_exp_in  = '0;
      s1_mant_in = '0;
      if (bits_ff == BITS_32) begin
         s1_sign_in = raw[31];
         s1_exp_in  = {3'b000, raw[30:23]} + F32_TO_F64;
         s1_mant_in = {1'b1, raw[22:0], 29'd0};
         if (raw[30:23] == 8'hFF) begin
            s1_zero_in = (raw[22:0] != '0);
            s1_sat_in  = (raw[22:0] == '0);
         end else if (raw[30:23] == 8'h00) begin
            s1_zero_in = 1'b1;
         end
      end else begin
         s1_sign_in = raw[63];
         s1_exp_in  = raw[62:52];
         s1_mant_in = {1'b1, raw[51:0]};
         if (raw[62:52] == EXP_MAX) begin
            s1_zero_in = (raw[51:0] != '0);
            s1_sat_in  = (raw[51:0] == '0);
         end else if (raw[62:52] == '0) begin
            s1_zero_in = 1'b1;
         end
      end
      case (bits_ff)
         BITS_8:  s1_int_in = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
         BITS_16: s1_int_in = raw[15:0];
         BITS_24: s1_int_in = raw[23:8];
         BITS_32: s1_int_in = raw[31:16];
         default: s1_int_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
      s1_last_ff  <= req_payload.last_in;
      s1_float_ff <= (format_ff == FMT_FLOAT);
      s1_sign_ff  <= s1_sign_in;
      s1_zero_ff  <= s1_zero_in;
      s1_sat_ff   <= s1_sat_in;
      s1_exp_ff   <= s1_exp_in;
      s1_mant_ff  <= s1_mant_in;
      s1_int_ff   <= s1_int_in;
   end

   // Stage 2: exact product mant * 32767 = (mant << 15) - mant.
   logic        s2_valid_ff;
   logic        s2_last_ff, s2_float_ff, s2_sign_ff, s2_zero_ff, s2_sat_ff;
   logic [10:0] s2_exp_ff;
   logic [67:0] s2_prod_ff;
   logic [15:0] s2_int_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_last_ff  <= s1_last_ff;
      s2_float_ff <= s1_float_ff;
      s2_sign_ff  <= s1_sign_ff;
      s2_zero_ff  <= s1_zero_ff;
      s2_sat_ff   <= s1_sat_ff;
      s2_exp_ff   <= s1_exp_ff;
      s2_prod_ff  <= {s1_mant_ff, 15'd0} - {15'd0, s1_mant_ff};
      s2_int_ff   <= s1_int_ff;
   end

   // Stage 3: round the product to 53 bits, nearest even, as the double
   // multiply does, and classify the magnitude by its exponent.
   logic        s3_valid_ff;
   logic        s3_last_ff, s3_float_ff, s3_sign_ff, s3_zero_ff, s3_sat_ff;
   logic        s3_half_ff;
   logic [53:0] s3_round_ff;
   logic [5:0]  s3_shift_ff;
   logic [15:0] s3_int_ff;

   logic [52:0] keep;
   logic        rbit, sticky;
   logic [11:0] exp_sum;
   logic [53:0] s3_round_in;
   logic [11:0] shift_wide;

   always_comb begin
      if (s2_prod_ff[67]) begin
         keep    = s2_prod_ff[67:15];
         rbit    = s2_prod_ff[14];
         sticky  = (s2_prod_ff[13:0] != '0);
         exp_sum = {1'b0, s2_exp_ff} + 12'd15;
      end else begin
         keep    = s2_prod_ff[66:14];
         rbit    = s2_prod_ff[13];
         sticky  = (s2_prod_ff[12:0] != '0);
         exp_sum = {1'b0, s2_exp_ff} + 12'd14;
      end
      s3_round_in = {1'b0, keep} + {53'd0, rbit && (sticky || keep[0])};
      shift_wide  = EXP_SHIFT_REF - exp_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_last_ff  <= s2_last_ff;
      s3_float_ff <= s2_float_ff;
      s3_sign_ff  <= s2_sign_ff;
      s3_zero_ff  <= s2_zero_ff || (exp_sum <= EXP_ZERO_MAX);
      s3_sat_ff   <= s2_sat_ff || (!s2_zero_ff && exp_sum >= EXP_SAT_MIN);
      // The largest double below one half: adding 0.5 in double precision
      // rounds the sum up to exactly 1.0, so its magnitude becomes one.
      s3_half_ff  <= (exp_sum == EXP_QUARTER) && (s3_round_in == {1'b0, {53{1'b1}}});
      s3_round_ff <= s3_round_in;
      s3_shift_ff <= shift_wide[5:0];
      s3_int_ff   <= s2_int_ff;
   end

   // Stage 4: round half away from zero on the magnitude, saturate, apply
   // the sign and register the result transaction.
   logic        rsp_valid_ff;
   logic [15:0] pcm_ff, pcm_in;
   logic        last_ff;

   logic [53:0] shifted;
   logic [16:0] mag;

   always_comb begin
      shifted = s3_round_ff >> s3_shift_ff;
      mag     = s3_half_ff ? 17'd1 : ((shifted[16:0] + 17'd1) >> 1);
      if (!s3_float_ff) begin
         pcm_in = s3_int_ff;
      end else if (s3_zero_ff) begin
         pcm_in = '0;
      end else if (s3_sat_ff) begin
         pcm_in = s3_sign_ff ? PCM_NEG_MAX : PCM_POS_MAX;
      end else if (s3_sign_ff) begin
         pcm_in = (mag >= 17'd32768) ? PCM_NEG_MAX : (16'd0 - mag[15:0]);
      end else begin
         pcm_in = (mag >= 17'd32767) ? PCM_POS_MAX : mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s3_valid_ff;
      pcm_ff  <= pcm_in;
      last_ff <= s3_last_ff;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_payload.pcm_sample = pcm_ff;
   assign rsp_payload.last_out   = last_ff;

   // A valid result must come from a valid stage-three item.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s3_valid_ff))
      else $error("result without a stage-three item");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("stage-two item without a stage-one item");

   a_pos_float: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_float_ff && !s3_sign_ff) |=> !rsp_payload.pcm_sample[15])
      else $error("positive float gave a negative sample");

   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_float_ff && s3_zero_ff) |=> (rsp_payload.pcm_sample == '0))
      else $error("zero-class float gave a nonzero sample");

endmodule

`default_nettype wire

// ----- tb/audio_sample_to_pcm16_checker.sv -----
// ----------------------------------------------------------------------------
// audio_sample_to_pcm16_checker: prediction and comparison for the converter
// Watches the sample, result and configuration channels, keeps its own copy
// of the format registers, predicts each converted sample and compares it
// field by field with the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_sample_to_pcm16_checker
   import aspcm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            busy,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire rsp_payload_type rsp_payload,
   input  wire logic            csr_valid,
   input  wire logic            csr_ready,
   input  wire logic            csr_index,
   input  wire logic [6:0]      csr_data,
   output      int              mismatch_count,
   output      int              samples_in_flight
);

   logic            fmt_shadow;
   logic [6:0]      bits_shadow;
   rsp_payload_type pending_pcm[$];

   // Scale, round half away from zero, saturate; NaN maps to zero.
   function automatic logic [15:0] scale_real_to_pcm(real v);
      real s;
      real r;
      s = v * 32767.0;
      if (s != s) return 16'h0000;
      r = (s >= 0.0) ? s + 0.5 : s - 0.5;
      if (r >= 32767.0) return PCM_POS_MAX;
      if (r <= -32768.0) return PCM_NEG_MAX;
      return 16'($rtoi(r));
   endfunction

   // Widens a float32 bit pattern to float64; subnormals round to zero anyway.
   function automatic logic [63:0] widen_float32(logic [31:0] w);
      logic [10:0] e;
      if (w[30:23] == 8'hFF) e = EXP_MAX;
      else if (w[30:23] == 8'h00) return {w[31], 63'd0};
      else e = {3'd0, w[30:23]} + F32_TO_F64;
      return {w[31], e, w[22:0], 29'd0};
   endfunction

   function automatic logic [15:0] convert_sample(logic fmt, logic [6:0] nbits,
                                                  logic [63:0] raw);
      if (fmt == FMT_FLOAT) begin
         if (nbits == BITS_32) return scale_real_to_pcm($bitstoreal(widen_float32(raw[31:0])));
         return scale_real_to_pcm($bitstoreal(raw));
      end
      case (nbits)
         BITS_8:  return {raw[7:0] ^ 8'h80, 8'h00};
         BITS_16: return raw[15:0];
         BITS_24: return raw[23:8];
         BITS_32: return raw[31:16];
         default: return 16'h0000;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int              errors;
      errors = 0;
      if (reset) begin
         fmt_shadow = FMT_PCM;
         bits_shadow = BITS_16;
         pending_pcm.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_pcm.size() == 0) begin
               $error("result transaction with no sample outstanding");
               errors++;
            end else begin
               want = pending_pcm.pop_front();
               if (rsp_payload.pcm_sample !== want.pcm_sample) begin
                  $error("pcm_sample: expected %h, actual %h",
                         want.pcm_sample, rsp_payload.pcm_sample);
                  errors++;
               end
               if (rsp_payload.last_out !== want.last_out) begin
                  $error("last_out: expected %b, actual %b",
                         want.last_out, rsp_payload.last_out);
                  errors++;
               end
            end
         end
         // A sample taken at this edge still sees the registers before any
         // write at the same edge.
         if (start && !busy) begin
            want.pcm_sample = convert_sample(fmt_shadow, bits_shadow,
                                             req_payload.sample_bytes);
            want.last_out = req_payload.last_in;
            pending_pcm.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SAMPLE_FORMAT) fmt_shadow = csr_data[0];
            else bits_shadow = csr_data;
         end
         mismatch_count <= mismatch_count + errors;
      end
      samples_in_flight <= pending_pcm.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_audio_sample_to_pcm16_unit.sv -----
// ----------------------------------------------------------------------------
// tb_audio_sample_to_pcm16_unit: testbench top for the PCM16 converter
// Steps through PCM and float settings, sends directed and random samples
// with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_audio_sample_to_pcm16_unit
   import aspcm_pkg::*;
();

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_index;
   logic [6:0]      csr_data;
   int              mismatch_count;
   int              samples_in_flight;
   int              quiet_cycles;

   // The unit has a four-stage pipeline; this is the settle time we allow
   // after the last result before touching configuration or finishing.
   localparam int SETTLE_CYCLES = 8;
   // Longest stretch with no transaction at all that the watchdog allows;
   // it covers the random gaps and the drain between phases.
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_COUNT = 10;

   audio_sample_to_pcm16_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   audio_sample_to_pcm16_checker pcm_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .mismatch_count(mismatch_count),
      .samples_in_flight(samples_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The watchdog counts cycles in which no transaction of any kind moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Writes one format register; the channel is held until it is taken.
   task automatic write_format_reg(logic idx, logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Presents one sample and returns on the edge that takes it. start stays
   // high so that back-to-back samples see no dip.
   task automatic send_sample(logic [63:0] raw, logic last);
      start <= 1'b1;
      req_payload.sample_bytes <= raw;
      req_payload.last_in <= last;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   // Lets every outstanding sample come back, then waits out the pipeline.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (samples_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random sample shaped for the current format. For float data a third of
   // the values lie near unit scale so rounding and saturation get exercised.
   function automatic logic [63:0] random_sample(logic fmt, logic [6:0] nbits);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if (fmt == FMT_FLOAT) begin
         case ($urandom_range(0, 5))
            0, 1: raw[62:52] = 11'($urandom_range(1000, 1040));
            2, 3: raw[30:23] = 8'($urandom_range(104, 144));
            4: raw[62:52] = ($urandom_range(0, 1) != 0) ? EXP_MAX : 11'h000;
            default: ;
         endcase
      end
      return raw;
   endfunction

   logic [63:0] directed_raw[15] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
      64'hFFFF_FFFF_3F80_0000, 64'h0000_0000_BF80_0000, 64'h0000_0000_7F80_0000,
      64'h0000_0000_7FC0_0000, 64'h0000_0000_0000_0080, 64'h0000_0000_0000_00FF
   };

   // Settings per phase: the supported widths, unsupported PCM widths, and
   // float widths other than 32 that fall back to double precision.
   logic       phase_fmt[PHASE_COUNT] = '{FMT_PCM, FMT_PCM, FMT_PCM, FMT_PCM, FMT_PCM,
                                         FMT_PCM, FMT_FLOAT, FMT_FLOAT, FMT_FLOAT,
                                         FMT_FLOAT};
   logic [6:0] phase_bits[PHASE_COUNT] = '{BITS_8, BITS_16, BITS_24, BITS_32, 7'd127,
                                          7'd0, BITS_32, 7'd64, 7'd0, 7'd127};

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_FORMAT;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first batch runs at reset settings, 16-bit PCM.
      foreach (directed_raw[i]) send_sample(directed_raw[i], i[0]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_pipeline();
         write_format_reg(CSR_SAMPLE_FORMAT, {6'd0, phase_fmt[p]});
         write_format_reg(CSR_SAMPLE_BITS, phase_bits[p]);
         // Extreme and special patterns for 8-bit PCM, float32 and float64.
         if (p == 0 || p == 6 || p == 7) begin
            foreach (directed_raw[i]) send_sample(directed_raw[i], i[0]);
         end
         for (int n = 0; n < 150; n++) begin
            send_sample(random_sample(phase_fmt[p], phase_bits[p]),
                        1'($urandom_range(0, 1)));
            // The last phase runs at full rate with no gaps.
            if (p < PHASE_COUNT - 1 && $urandom_range(0, 7) == 0) idle_burst();
         end
      end

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
